// File: rtl/lrpg_pkg.sv
// Package for the LED rail power gating policy.
// Operation, mode and action codes, word and state types. No dependencies.
package lrpg_pkg;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned DARK_W = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [DELAY_W-1:0] BLACKOUT_DELAY_RST = 16'd1000;
  localparam logic [DELAY_W-1:0] SETTLE_TIME_RST = 16'd5;
  localparam logic [DARK_W-1:0] DARK_MAX = {DARK_W{1'b1}};

  typedef enum logic [1:0] {
    OP_FRAME       = 2'd0,
    OP_FORCE_GATED = 2'd1,
    OP_RESET_LIT   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_LIT      = 2'd0,
    MODE_GATED    = 2'd1,
    MODE_SETTLING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_TRANSMIT = 2'd0,
    ACT_GATE_OFF = 2'd1,
    ACT_SKIP     = 2'd2,
    ACT_WAKE     = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLACKOUT_DELAY = 1'd0,
    REG_SETTLE_TIME    = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic                 frame_lit;
    logic [ELAPSED_W-1:0] elapsed;
  } in_word_t;

  typedef struct packed {
    logic [1:0] action;
    logic       stable;
  } out_word_t;

  typedef struct packed {
    mode_t               mode;
    logic [DARK_W-1:0]   dark_time;
    logic [DELAY_W-1:0]  settle_left;
  } policy_state_t;

  typedef struct packed {
    logic [DELAY_W-1:0] blackout_delay;
    logic [DELAY_W-1:0] settle_time;
  } cfg_t;

endpackage

// File: rtl/lrpg_stream_if.sv
// Valid/ready stream interfaces for frame words and result words.
// Depends on lrpg_pkg for field widths.
interface lrpg_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic                           frame_lit;
  logic [lrpg_pkg::ELAPSED_W-1:0] elapsed;

  modport source (output valid, output operation, output frame_lit, output elapsed,
                  input ready);
  modport sink (input valid, input operation, input frame_lit, input elapsed,
                output ready);
endinterface

interface lrpg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       stable;

  modport source (output valid, output action, output stable, input ready);
  modport sink (input valid, input action, input stable, output ready);
endinterface

// File: rtl/lrpg_cfg_regs.sv
// Configuration registers: blackout delay and settle time.
// Depends on lrpg_pkg.
module lrpg_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lrpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrpg_pkg::DELAY_W-1:0] cfg_wdata,
  output lrpg_pkg::cfg_t               cfg
);

  lrpg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blackout_delay <= lrpg_pkg::BLACKOUT_DELAY_RST;
      cfg_r.settle_time    <= lrpg_pkg::SETTLE_TIME_RST;
    end else if (cfg_we) begin
      unique case (lrpg_pkg::cfg_idx_t'(cfg_index))
        lrpg_pkg::REG_BLACKOUT_DELAY: cfg_r.blackout_delay <= cfg_wdata;
        lrpg_pkg::REG_SETTLE_TIME:    cfg_r.settle_time    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/lrpg_policy_core.sv
// Next-state and result logic for one word of the gating policy.
// Depends on lrpg_pkg.
module lrpg_policy_core (
  input  lrpg_pkg::in_word_t      word,
  input  lrpg_pkg::cfg_t          cfg,
  input  lrpg_pkg::policy_state_t st,
  output lrpg_pkg::policy_state_t st_nxt,
  output lrpg_pkg::out_word_t     res
);

  logic [lrpg_pkg::DARK_W:0]    dark_sum;
  logic [lrpg_pkg::DARK_W-1:0]  dark_sat;
  logic                         dark_expired;
  logic                         settle_running;
  lrpg_pkg::action_t            action;

  // dark accumulate, saturating; compare against delay
  assign dark_sum = {1'b0, st.dark_time} + {{(lrpg_pkg::DARK_W + 1 - lrpg_pkg::ELAPSED_W){1'b0}},
                                            word.elapsed};
  assign dark_sat = dark_sum[lrpg_pkg::DARK_W] ? lrpg_pkg::DARK_MAX
                                               : dark_sum[lrpg_pkg::DARK_W-1:0];
  assign dark_expired = dark_sat >= {{(lrpg_pkg::DARK_W - lrpg_pkg::DELAY_W){1'b0}},
                                     cfg.blackout_delay};
  assign settle_running = st.settle_left > word.elapsed;

  // next state
  always_comb begin
    st_nxt = st;
    unique case (word.operation)
      lrpg_pkg::OP_FRAME: begin
        unique case (st.mode)
          lrpg_pkg::MODE_GATED: begin
            if (word.frame_lit) begin
              st_nxt.mode        = lrpg_pkg::MODE_SETTLING;
              st_nxt.settle_left = cfg.settle_time;
            end
          end
          lrpg_pkg::MODE_SETTLING: begin
            if (settle_running) begin
              st_nxt.settle_left = st.settle_left - word.elapsed;
            end else begin
              st_nxt.settle_left = '0;
              st_nxt.mode        = lrpg_pkg::MODE_LIT;
            end
          end
          default: begin
            // lit, and the unused code behaves as lit
            st_nxt.mode = lrpg_pkg::MODE_LIT;
            if (word.frame_lit) begin
              st_nxt.dark_time = '0;
            end else if (dark_expired) begin
              st_nxt.mode      = lrpg_pkg::MODE_GATED;
              st_nxt.dark_time = '0;
            end else begin
              st_nxt.dark_time = dark_sat;
            end
          end
        endcase
      end
      lrpg_pkg::OP_FORCE_GATED: begin
        st_nxt.mode        = lrpg_pkg::MODE_GATED;
        st_nxt.dark_time   = '0;
        st_nxt.settle_left = '0;
      end
      lrpg_pkg::OP_RESET_LIT: begin
        st_nxt.mode        = lrpg_pkg::MODE_LIT;
        st_nxt.dark_time   = '0;
        st_nxt.settle_left = '0;
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    action = lrpg_pkg::ACT_TRANSMIT;
    if (word.operation == lrpg_pkg::OP_FRAME) begin
      unique case (st.mode)
        lrpg_pkg::MODE_GATED:
          action = word.frame_lit ? lrpg_pkg::ACT_WAKE : lrpg_pkg::ACT_SKIP;
        lrpg_pkg::MODE_SETTLING:
          action = settle_running ? lrpg_pkg::ACT_SKIP : lrpg_pkg::ACT_TRANSMIT;
        default:
          action = (!word.frame_lit && dark_expired) ? lrpg_pkg::ACT_GATE_OFF
                                                     : lrpg_pkg::ACT_TRANSMIT;
      endcase
    end
    res.action = action;
    unique case (st_nxt.mode)
      lrpg_pkg::MODE_GATED:    res.stable = 1'b1;
      lrpg_pkg::MODE_SETTLING: res.stable = 1'b0;
      default:                 res.stable = (st_nxt.dark_time == '0);
    endcase
  end

endmodule

// File: rtl/led_rail_power_gating_policy.sv
// Top level of the LED rail power gating policy.
// Depends on lrpg_pkg, lrpg_stream_if, lrpg_cfg_regs and lrpg_policy_core.

// One frame word in, one result word out. A word accepted on in_ch lands in
// an input register. From there the policy logic (one 17-bit saturating
// add and compare, one 16-bit compare and subtract) forms the next mode, dark
// and settle state and the result word; the state register and the result
// register load together when the result slot is free, and the result is then
// valid on out_ch. Sustained rate is one word per cycle while out_ch does not stall:
// the input register refills in the same cycle it hands its word on, and
// out_ch back-pressure only stalls the pipe, never drops or repeats a word.
// State updates in acceptance order, so back-to-back frames see the state the
// previous frame left. Registers (blackout_delay index 0, settle_time index 1)
// are to be written through cfg_we/cfg_index/cfg_wdata only while idle; the
// block itself does not enforce this.
module led_rail_power_gating_policy (
  input  logic                           clk,
  input  logic                           rst_n,
  lrpg_in_if.sink                        in_ch,
  lrpg_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lrpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrpg_pkg::DELAY_W-1:0]   cfg_wdata
);

  lrpg_pkg::cfg_t          cfg;
  lrpg_pkg::policy_state_t st_r;
  lrpg_pkg::policy_state_t st_nxt;
  lrpg_pkg::in_word_t      in_word_r;
  lrpg_pkg::out_word_t     res_nxt;
  lrpg_pkg::out_word_t     res_r;
  logic                    in_valid_r;
  logic                    out_valid_r;
  logic                    advance;
  logic                    in_take;

  lrpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lrpg_policy_core u_core (
    .word   (in_word_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // result slot is free when empty or being drained this cycle
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r.operation <= in_ch.operation;
      in_word_r.frame_lit <= in_ch.frame_lit;
      in_word_r.elapsed   <= in_ch.elapsed;
    end
  end

  // policy state commits only when the word moves into the result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode        <= lrpg_pkg::MODE_LIT;
      st_r.dark_time   <= '0;
      st_r.settle_left <= '0;
    end else if (in_valid_r && advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.action = res_r.action;
  assign out_ch.stable = res_r.stable;

endmodule

// File: bench/tb_led_rail_power_gating_policy.sv
`timescale 1ns / 1ps
// Self-checking bench for led_rail_power_gating_policy: directed and random frame words
// checked against an in-bench policy predictor. Uses lrpg_pkg and lrpg_stream_if.
module tb_led_rail_power_gating_policy;
  import lrpg_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  // Pipe is two deep; a few extra cycles catch stray result words.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 65;
  localparam int HOLD_CYCLES  = 300;

  // Operation code 3 has no package name; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  logic [DELAY_W-1:0] cfg_wdata;

  lrpg_in_if  in_ch ();
  lrpg_out_if out_ch ();

  led_rail_power_gating_policy dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the policy state, reset values from the package.
  logic [DELAY_W-1:0] gate_delay_ms  = BLACKOUT_DELAY_RST;
  logic [DELAY_W-1:0] wake_delay_ms  = SETTLE_TIME_RST;
  mode_t              rail_mode      = MODE_LIT;
  logic [DARK_W-1:0]  dark_ms        = '0;
  logic [DELAY_W-1:0] wake_remain_ms = '0;

  // Expected result words, oldest first.
  out_word_t expected_q[$];

  int mismatches  = 0;
  int cycle_count = 0;

  // Idle knobs: percent of words preceded by a gap, percent of cycles the sink stalls,
  // and a one-shot long hold-off picked up by the sink process.
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int rx_hold_cycles = 0;

  // Advance the predicted policy by one word and return the result it causes.
  function automatic out_word_t predict_policy(logic [1:0] op, logic lit,
                                               logic [ELAPSED_W-1:0] ms);
    out_word_t       res;
    logic [DARK_W:0] dark_sum;
    res.action = ACT_TRANSMIT;
    if (op == OP_FRAME) begin
      case (rail_mode)
        MODE_GATED: begin
          // dark frames stay gated; a lit one wakes the rail
          if (!lit) begin
            res.action = ACT_SKIP;
          end else begin
            rail_mode      = MODE_SETTLING;
            wake_remain_ms = wake_delay_ms;
            res.action     = ACT_WAKE;
          end
        end
        MODE_SETTLING: begin
          if (wake_remain_ms > ms) begin
            wake_remain_ms = wake_remain_ms - ms;
            res.action     = ACT_SKIP;
          end else begin
            wake_remain_ms = '0;
            rail_mode      = MODE_LIT;
            res.action     = ACT_TRANSMIT;
          end
        end
        default: begin
          rail_mode = MODE_LIT;
          if (lit) begin
            dark_ms = '0;
          end else begin
            // saturating accumulate of dark time
            dark_sum = {1'b0, dark_ms} + {{(DARK_W + 1 - ELAPSED_W){1'b0}}, ms};
            dark_ms  = (dark_sum > {1'b0, DARK_MAX}) ? DARK_MAX : dark_sum[DARK_W-1:0];
            if (dark_ms >= DARK_W'(gate_delay_ms)) begin
              rail_mode  = MODE_GATED;
              dark_ms    = '0;
              res.action = ACT_GATE_OFF;
            end
          end
        end
      endcase
    end else if (op == OP_FORCE_GATED) begin
      dark_ms        = '0;
      wake_remain_ms = '0;
      rail_mode      = MODE_GATED;
    end else if (op == OP_RESET_LIT) begin
      dark_ms        = '0;
      wake_remain_ms = '0;
      rail_mode      = MODE_LIT;
    end
    // stable is taken after the update
    case (rail_mode)
      MODE_GATED:    res.stable = 1'b1;
      MODE_SETTLING: res.stable = 1'b0;
      default:       res.stable = (dark_ms == '0);
    endcase
    return res;
  endfunction

  // Monitor: everything is sampled at the rising edge, before any NBA of this step lands.
  // Result words are checked first; a word accepted this edge cannot have its result yet.
  always @(posedge clk) begin : monitor
    out_word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: result word with none expected: action=%0d stable=%0d",
                   cycle_count, out_ch.action, out_ch.stable);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.action !== want.action || out_ch.stable !== want.stable) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: expected action=%0d stable=%0d, got action=%0d stable=%0d",
                     cycle_count, want.action, want.stable, out_ch.action, out_ch.stable);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_q.push_back(predict_policy(in_ch.operation, in_ch.frame_lit, in_ch.elapsed));
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_BLACKOUT_DELAY: gate_delay_ms = cfg_wdata;
        REG_SETTLE_TIME:    wake_delay_ms = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sink side. Random stalls, occasional long ones, and the one-shot hold-off that lets
  // the pipe fill up and push back on the sender. The hold-off is counted here.
  initial begin : sink_side
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else if (rx_stall_pct > 0 && $urandom_range(99) < 2) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(40, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Gap before the next word: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (tx_idle_pct == 0) return 0;
    r = $urandom_range(99);
    if (r >= tx_idle_pct) return 0;
    if (r < 3) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Elapsed ms: zero, all ones, full range, and a lot scaled to the current
  // settings so dark runs and settle countdowns take a few frames.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int unsigned span;
    int unsigned r;
    r    = $urandom_range(99);
    span = ((gate_delay_ms > wake_delay_ms) ? gate_delay_ms : wake_delay_ms) / 3 + 1;
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 34) return ELAPSED_W'($urandom);
    return ELAPSED_W'($urandom_range(span, 0));
  endfunction

  // Send one word. Called at a rising edge; returns at the edge that accepted it.
  // valid is left high, so back-to-back words never drop it.
  task automatic send_word(logic [1:0] op, logic lit, logic [ELAPSED_W-1:0] ms);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.frame_lit <= lit;
    in_ch.elapsed   <= ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    int         r;
    logic [1:0] op;
    r = $urandom_range(99);
    if (r < 84)      op = OP_FRAME;
    else if (r < 89) op = OP_FORCE_GATED;
    else if (r < 95) op = OP_RESET_LIT;
    else             op = OP_UNKNOWN;
    send_word(op, $urandom_range(99) < 35, pick_elapsed());
  endtask

  // Stop sending and wait until every expected word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the pipe empty.
  task automatic set_policy(logic [DELAY_W-1:0] delay_ms, logic [DELAY_W-1:0] wait_ms);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLACKOUT_DELAY;
    cfg_wdata <= delay_ms;
    @(posedge clk);
    cfg_index <= REG_SETTLE_TIME;
    cfg_wdata <= wait_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset settings (1000 ms, 5 ms): full lit/gated/settling loop, control ops, op 3.
  task automatic test_default_policy();
    tx_idle_pct  = 30;
    rx_stall_pct = 20;
    send_word(OP_FRAME, 1'b1, 16'hFFFF);       // elapsed ignored on lit frame
    send_word(OP_FRAME, 1'b0, 16'd999);        // countdown running, not stable
    send_word(OP_UNKNOWN, 1'b0, 16'd0);        // no-op, stable shows running count
    send_word(OP_FRAME, 1'b0, 16'd1);          // reaches delay exactly: gate off
    send_word(OP_FRAME, 1'b0, 16'hFFFF);       // dark while gated: skip
    send_word(OP_FRAME, 1'b1, 16'hFFFF);       // wake
    send_word(OP_FRAME, 1'b1, 16'd3);          // settle 5 -> 2
    send_word(OP_FRAME, 1'b0, 16'd2);          // countdown out: transmit, back to lit
    send_word(OP_FRAME, 1'b0, 16'd500);
    send_word(OP_RESET_LIT, 1'b1, 16'hFFFF);   // clears dark count
    send_word(OP_FORCE_GATED, 1'b0, 16'd0);
    send_word(OP_UNKNOWN, 1'b1, 16'hFFFF);     // no-op while gated
    send_word(OP_FRAME, 1'b1, 16'd0);          // wake
    send_word(OP_RESET_LIT, 1'b0, 16'd0);      // leave settling by control op
    drain();
  endtask

  // Zero and full-scale register values.
  task automatic test_limit_settings();
    set_policy(16'd0, 16'd0);
    send_word(OP_FRAME, 1'b0, 16'd0);          // zero delay: first dark frame gates
    send_word(OP_FRAME, 1'b1, 16'd0);          // wake
    send_word(OP_FRAME, 1'b0, 16'd0);          // zero settle: transmit at once
    set_policy(16'hFFFF, 16'hFFFF);
    send_word(OP_FRAME, 1'b0, 16'hFFFE);
    send_word(OP_FRAME, 1'b0, 16'hFFFF);       // largest dark sum, gates
    send_word(OP_FRAME, 1'b1, 16'd0);          // wake, settle 65535
    send_word(OP_FRAME, 1'b0, 16'hFFFE);       // 1 left
    send_word(OP_FRAME, 1'b1, 16'd1);          // equal: transmit
    send_word(OP_FRAME, 1'b0, 16'hFFFF);       // one full frame reaches delay
    drain();
  endtask

  // Sink holds off while the sender keeps offering words back to back.
  task automatic test_back_pressure();
    set_policy(16'd300, 16'd40);
    tx_idle_pct    = 0;
    rx_stall_pct   = 10;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (40) send_random_word();
    drain();
  endtask

  // Random phases over several settings; one phase runs with no idling at all.
  task automatic test_random_phases();
    logic [DELAY_W-1:0] delay_ms;
    logic [DELAY_W-1:0] wait_ms;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin delay_ms = 16'd1;      wait_ms = 16'd1;      end
        1: begin delay_ms = 16'd0;      wait_ms = 16'hFFFF;   end
        2: begin delay_ms = 16'hFFFF;   wait_ms = 16'd0;      end
        3: begin
          delay_ms = DELAY_W'($urandom_range(2000));
          wait_ms  = DELAY_W'($urandom_range(200));
        end
        4: begin delay_ms = DELAY_W'($urandom); wait_ms = DELAY_W'($urandom); end
        default: begin delay_ms = BLACKOUT_DELAY_RST; wait_ms = SETTLE_TIME_RST; end
      endcase
      set_policy(delay_ms, wait_ms);
      case (phase)
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        4:       begin tx_idle_pct = 60; rx_stall_pct = 60; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      repeat (PHASE_WORDS) send_random_word();
    end
    drain();
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_BLACKOUT_DELAY;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_FRAME;
    in_ch.frame_lit <= 1'b0;
    in_ch.elapsed   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_policy();
    test_limit_settings();
    test_back_pressure();
    test_random_phases();

    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
